### hdl/rpc_pkg.sv
package rpc_pkg;

  localparam int NUM_CLASSES = 6;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [15:0] PIX_GAP16   = 16'hFFFF;
  localparam logic [7:0]  LOW_BYTE_FF = 8'hFF;
  localparam logic [15:0] PIX_HIS16   = 16'd16383;
  localparam logic [15:0] PIX_GAP8    = 16'd255;
  localparam logic [15:0] PIX_HIS8    = 16'd254;
  localparam logic [31:0] CNT_MAX     = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam logic REG_EIGHT_BIT  = 1'b0;
  localparam logic REG_LSB_NULLS  = 1'b1;

  typedef enum logic [2:0] {
    CLS_VALID   = 3'd0,
    CLS_GAP     = 3'd1,
    CLS_SUSPECT = 3'd2,
    CLS_INVALID = 3'd3,
    CLS_HIS     = 3'd4,
    CLS_LIS     = 3'd5
  } class_t;

  // one classified pixel on its way to the counter stage
  typedef struct packed {
    logic [15:0] value;
    class_t      cls;
    logic        nul;
    logic [2:0]  section;
    logic        last;
  } rec_t;

  // pushes from the front into the queue
  typedef struct packed {
    logic [1:0] push_n;
    rec_t       rec_a;
    rec_t       rec_b;
  } push_t;

  function automatic class_t class16(input logic [15:0] px, input logic next_gap);
    class_t c;
    if (px == PIX_GAP16) c = CLS_GAP;
    else if (next_gap && (px[7:0] == LOW_BYTE_FF)) c = CLS_SUSPECT;
    else if (px > PIX_HIS16) c = CLS_INVALID;
    else if (px == PIX_HIS16) c = CLS_HIS;
    else if (px == 16'd0) c = CLS_LIS;
    else c = CLS_VALID;
    return c;
  endfunction

  function automatic class_t class8(input logic [15:0] px);
    class_t c;
    if (px == PIX_GAP8) c = CLS_GAP;
    else if (px == PIX_HIS8) c = CLS_HIS;
    else if (px == 16'd0) c = CLS_LIS;
    else c = CLS_VALID;
    return c;
  endfunction

  function automatic logic null_of(input class_t c, input logic lsb_nulls);
    logic n;
    if (c == CLS_GAP || c == CLS_INVALID) n = 1'b1;
    else if (c == CLS_SUSPECT) n = lsb_nulls;
    else n = 1'b0;
    return n;
  endfunction

endpackage

### hdl/rpc_if.sv
interface rpc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_raw;
  logic [2:0]  section;
  logic        line_end;
  modport source (output valid, pixel_raw, section, line_end, input ready);
  modport sink   (input valid, pixel_raw, section, line_end, output ready);
endinterface

interface rpc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_value;
  logic [2:0]  pixel_class;
  logic        replaced_null;
  logic [31:0] class_count;
  logic [2:0]  section_out;
  logic        last;
  modport source (output valid, pixel_value, pixel_class, replaced_null, class_count,
                  section_out, last, input ready);
  modport sink   (input valid, pixel_value, pixel_class, replaced_null, class_count,
                  section_out, last, output ready);
endinterface

interface rpc_cfg_if;
  logic valid;
  logic ready;
  logic index;
  logic data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/rpc_front.sv
module rpc_front
  import rpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  rpc_in_if.sink    pix_in,
  rpc_cfg_if.sink   cfg,
  input  logic      q_room,
  output push_t     push
);

  logic        eight_bit_mode;
  logic        lsb_gap_nulls;
  logic [15:0] held_pixel;
  logic [2:0]  held_section;
  logic        held_present;

  logic   take;
  logic   new_emit;
  class_t held_cls;
  class_t new_cls;
  rec_t   held_rec;
  rec_t   new_rec;

  assign cfg.ready    = 1'b1;
  assign pix_in.ready = q_room;
  assign take         = pix_in.valid && pix_in.ready;
  assign new_emit     = eight_bit_mode || pix_in.line_end;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      eight_bit_mode <= 1'b0;
      lsb_gap_nulls  <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_EIGHT_BIT: eight_bit_mode <= cfg.data;
        REG_LSB_NULLS: lsb_gap_nulls  <= cfg.data;
        default: ;
      endcase
    end
  end

  // classify the held pixel against its successor, and the new one alone
  always_comb begin
    held_cls = class16(held_pixel, !eight_bit_mode && (pix_in.pixel_raw == PIX_GAP16));
    new_cls  = eight_bit_mode ? class8(pix_in.pixel_raw) : class16(pix_in.pixel_raw, 1'b0);
    held_rec = '{value: held_pixel, cls: held_cls, nul: null_of(held_cls, lsb_gap_nulls),
                 section: held_section, last: 1'b0};
    new_rec  = '{value: pix_in.pixel_raw, cls: new_cls, nul: null_of(new_cls, lsb_gap_nulls),
                 section: pix_in.section, last: pix_in.line_end};
  end

  // pack up to two records per transfer
  always_comb begin
    push.rec_a  = held_present ? held_rec : new_rec;
    push.rec_b  = new_rec;
    push.push_n = 2'd0;
    if (take) begin
      push.push_n = 2'(held_present) + 2'(new_emit);
    end
  end

  // hold a pixel that still waits for its successor
  always_ff @(posedge clk) begin
    if (rst) begin
      held_present <= 1'b0;
    end else if (take) begin
      held_present <= !new_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !new_emit) begin
      held_pixel   <= pix_in.pixel_raw;
      held_section <= pix_in.section;
    end
  end

endmodule

### hdl/rpc_queue.sv
module rpc_queue
  import rpc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  nonempty,
  output rec_t  head,
  input  logic  pop
);

  rec_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign room     = (count <= QCNT_W'(QDEPTH - 2));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.push_n);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count + QCNT_W'(push.push_n) - QCNT_W'(pop);
    end
  end

  // store pushed records
  always_ff @(posedge clk) begin
    if (push.push_n != 2'd0) begin
      slots[wr_ptr] <= push.rec_a;
    end
    if (push.push_n == 2'd2) begin
      slots[wr_ptr + QPTR_W'(1)] <= push.rec_b;
    end
  end

endmodule

### hdl/rpc_back.sv
module rpc_back
  import rpc_pkg::*;
#(
  parameter int NUM_SECTIONS = 6
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      nonempty,
  input  rec_t      head,
  output logic      pop,
  rpc_out_if.source pix_out
);

  localparam int DEPTH = NUM_SECTIONS * NUM_CLASSES;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [31:0]      counters [DEPTH];
  logic [DEPTH-1:0] cnt_valid;

  logic             head_in_range;
  logic [IDX_W-1:0] head_idx;

  // counter stage registers
  logic             b_valid;
  rec_t             b_rec;
  logic             b_in_range;
  logic [IDX_W-1:0] b_idx;
  logic [31:0]      b_rdata;
  logic             b_hit;
  logic             b_byp;
  logic [31:0]      b_byp_val;

  logic        out_valid;
  logic        b_adv;
  logic [31:0] base;
  logic [31:0] cnt_next;

  assign head_in_range = (32'(head.section) < NUM_SECTIONS);
  assign head_idx      = IDX_W'(32'(head.section) * NUM_CLASSES + 32'(head.cls));

  assign b_adv = b_valid && (!out_valid || pix_out.ready);
  assign pop   = nonempty && (!b_valid || b_adv);

  // saturating increment, with the value just written forwarded
  always_comb begin
    if (b_byp) base = b_byp_val;
    else if (b_hit) base = b_rdata;
    else base = '0;
    cnt_next = (base == CNT_MAX) ? base : base + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (pop) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  // load the counter stage and read the counter memory
  always_ff @(posedge clk) begin
    if (pop) begin
      b_rec      <= head;
      b_in_range <= head_in_range;
      b_idx      <= head_idx;
      b_rdata    <= counters[head_idx];
      b_hit      <= cnt_valid[head_idx];
      b_byp      <= b_adv && b_in_range && head_in_range && (b_idx == head_idx);
      b_byp_val  <= cnt_next;
    end
  end

  // write the counter back
  always_ff @(posedge clk) begin
    if (b_adv && b_in_range) begin
      counters[b_idx] <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid <= '0;
    end else if (b_adv && b_in_range) begin
      cnt_valid[b_idx] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_adv) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      pix_out.pixel_value   <= b_rec.value;
      pix_out.pixel_class   <= b_rec.cls;
      pix_out.replaced_null <= b_rec.nul;
      pix_out.class_count   <= b_in_range ? cnt_next : 32'd0;
      pix_out.section_out   <= b_rec.section;
      pix_out.last          <= b_rec.last;
    end
  end

  assign pix_out.valid = out_valid;

endmodule

### hdl/raw_pixel_classifier.sv
// Raw pixel classifier: takes one pixel per clock and sustains one transfer per
// clock on each side while the queue has room and the output does not stall. A
// pixel gives zero, one or two results (in 16-bit mode a pixel is held until
// its successor arrives; a line end or a switch to 8-bit mode flushes it). The
// front classifies and pushes records into a four-entry queue; the back does
// one read-modify-write of the 36-entry counter memory per cycle, so results
// leave at most one per clock; counters clear at reset via per-entry valid bits.
module raw_pixel_classifier
  import rpc_pkg::*;
#(
  parameter int NUM_SECTIONS = 6
) (
  input  logic      clk,
  input  logic      rst,
  rpc_in_if.sink    pix_in,
  rpc_out_if.source pix_out,
  rpc_cfg_if.sink   cfg
);

  push_t push;
  logic  q_room;
  logic  q_nonempty;
  rec_t  q_head;
  logic  q_pop;

  rpc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .pix_in (pix_in),
    .cfg    (cfg),
    .q_room (q_room),
    .push   (push)
  );

  rpc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (q_room),
    .nonempty (q_nonempty),
    .head     (q_head),
    .pop      (q_pop)
  );

  rpc_back #(.NUM_SECTIONS(NUM_SECTIONS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .nonempty (q_nonempty),
    .head     (q_head),
    .pop      (q_pop),
    .pix_out  (pix_out)
  );

endmodule

### hdl/rpc_checker.sv
module rpc_checker
  import rpc_pkg::*;
#(
  parameter int NUM_SECTIONS = 6
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] pixel_value,
  input logic [2:0]  pixel_class,
  input logic        replaced_null,
  input logic [31:0] class_count
,
  input logic [2:0]  section_out
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_value) && $stable(class_count))
    else $error("stalled result changed");

  // gaps and invalid pixels always become null
  a_null_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && (pixel_class == CLS_GAP || pixel_class == CLS_INVALID) |-> replaced_null)
    else $error("gap or invalid pixel not nulled");

  // valid and saturated pixels never become null
  a_null_keep: assert property (@(posedge clk) disable iff (rst)
    out_valid && (pixel_class == CLS_VALID || pixel_class == CLS_HIS ||
                  pixel_class == CLS_LIS) |-> !replaced_null)
    else $error("kept pixel nulled");

  // a counted section reports a nonzero count, others report zero
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((32'(section_out) < NUM_SECTIONS) == (class_count != 32'd0)))
    else $error("class count does not match section range");

endmodule

bind raw_pixel_classifier rpc_checker #(.NUM_SECTIONS(NUM_SECTIONS)) u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (pix_out.valid),
  .out_ready     (pix_out.ready),
  .pixel_value   (pix_out.pixel_value),
  .pixel_class   (pix_out.pixel_class),
  .replaced_null (pix_out.replaced_null),
  .class_count   (pix_out.class_count),
  .section_out   (pix_out.section_out)
);
